// ===== rtl/shs_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 stream hasher.
// Used by shs_front, shs_core and the top level; depends on nothing.
package shs_pkg;

    localparam int unsigned BLOCK_BITS = 512;
    localparam int unsigned WORDS      = 8;
    localparam int unsigned SCHED      = 16;

    // command queue between front end and core; pointers are 2 bits wide
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // One queued command: a message byte and/or an end mark
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_bstate;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/shs_front.sv =====
// Input side: takes stream transactions, drops empty ones, queues commands.
// Depends on shs_pkg.
module shs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [7:0]    i_data,
    input  logic          i_has,
    input  logic          i_fin,
    output shs_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);

    shs_pkg::t_cmd r_q [shs_pkg::QUEUE_DEPTH];
    logic [1:0]    r_wr, r_rd;
    logic [2:0]    r_cnt;
    logic          push, pop;

    assign o_tready    = (r_cnt != 3'(shs_pkg::QUEUE_DEPTH));
    // items with neither byte nor end mark change nothing: not queued
    assign push        = i_tvalid && o_tready && (i_has || i_fin);
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{data: i_data, has: i_has, fin: i_fin};
        end
    end

endmodule

// ===== rtl/shs_core.sv =====
// Back end: block assembly, padding, 64-round compression and digest output.
// Depends on shs_pkg.
module shs_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  shs_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [31:0]   o_word,
    output logic [2:0]    o_index,
    output logic          o_last
);

    shs_pkg::t_bstate r_state, n_state;

    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_bits, n_bits;
    logic [31:0]  r_h [8];
    logic [31:0]  n_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  n_v [8];
    logic [31:0]  r_w [16];
    logic [31:0]  n_w [16];
    logic [5:0]   r_round, n_round;
    logic         r_pad, n_pad;     // message ended, padding in progress
    logic         r_mark, n_mark;   // 0x80 placed
    logic         r_lenok, n_lenok; // length may go at bytes 56..63 of this block
    logic         r_done, n_done;   // last length byte placed
    logic [2:0]   r_widx, n_widx;
    logic         r_ovalid, n_ovalid;
    logic [31:0]  r_oword, n_oword;
    logic [2:0]   r_oidx, n_oidx;

    logic         sh_en;
    logic [7:0]   sh_byte;
    logic [511:0] blk_in;
    logic [31:0]  t1, t2, w_new;

    assign blk_in = {r_blk[503:0], sh_byte};

    assign t1 = r_v[7] + shs_pkg::big_sig1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + shs_pkg::K_ROUND[r_round] + r_w[0];
    assign t2 = shs_pkg::big_sig0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = r_w[0] + shs_pkg::sml_sig0(r_w[1]) + r_w[9]
                 + shs_pkg::sml_sig1(r_w[14]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= shs_pkg::ST_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_h      <= shs_pkg::H_INIT;
            r_round  <= '0;
            r_pad    <= 1'b0;
            r_mark   <= 1'b0;
            r_lenok  <= 1'b0;
            r_done   <= 1'b0;
            r_widx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_h      <= n_h;
            r_round  <= n_round;
            r_pad    <= n_pad;
            r_mark   <= n_mark;
            r_lenok  <= n_lenok;
            r_done   <= n_done;
            r_widx   <= n_widx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk   <= n_blk;
        r_v     <= n_v;
        r_w     <= n_w;
        r_oword <= n_oword;
        r_oidx  <= n_oidx;
    end

    always_comb begin
        n_state   = r_state;
        n_blk     = r_blk;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_h       = r_h;
        n_v       = r_v;
        n_w       = r_w;
        n_round   = r_round;
        n_pad     = r_pad;
        n_mark    = r_mark;
        n_lenok   = r_lenok;
        n_done    = r_done;
        n_widx    = r_widx;
        n_ovalid  = r_ovalid && !i_tready;
        n_oword   = r_oword;
        n_oidx    = r_oidx;
        o_cmd_pop = 1'b0;
        sh_en     = 1'b0;
        sh_byte   = '0;

        unique case (r_state)
            shs_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    if (i_cmd.has) begin
                        sh_en   = 1'b1;
                        sh_byte = i_cmd.data;
                        n_bits  = r_bits + 64'd8;
                    end
                    if (i_cmd.fin) begin
                        n_pad   = 1'b1;
                        n_mark  = 1'b0;
                        n_lenok = 1'b0;
                        n_done  = 1'b0;
                        n_state = shs_pkg::ST_PAD;
                    end
                end
            end
            shs_pkg::ST_PAD: begin
                sh_en = 1'b1;
                priority if (!r_mark) begin
                    sh_byte = shs_pkg::PAD_MARK;
                    n_mark  = 1'b1;
                    n_lenok = (r_fill < shs_pkg::LEN_START);
                end else if (r_lenok && (r_fill >= shs_pkg::LEN_START)) begin
                    // length goes out big-endian, top byte first
                    sh_byte = r_bits[63:56];
                    n_bits  = {r_bits[55:0], 8'h00};
                    n_done  = (r_fill == shs_pkg::FILL_LAST);
                end else begin
                    sh_byte = 8'h00;
                end
            end
            shs_pkg::ST_COMP: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[15] = w_new;
                n_round = r_round + 6'd1;
                if (r_round == shs_pkg::ROUND_LAST) begin
                    n_state = shs_pkg::ST_ADD;
                end
            end
            shs_pkg::ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                priority if (r_done) begin
                    n_widx  = '0;
                    n_state = shs_pkg::ST_OUT;
                end else if (r_pad) begin
                    // padding goes on: if the mark was placed, the length fits in this next block
                    n_lenok = r_mark;
                    n_state = shs_pkg::ST_PAD;
                end else begin
                    n_state = shs_pkg::ST_IDLE;
                end
            end
            shs_pkg::ST_OUT: begin
                if (!r_ovalid || i_tready) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_h[r_widx];
                    n_oidx   = r_widx;
                    n_widx   = r_widx + 3'd1;
                    if (r_widx == shs_pkg::WORD_LAST) begin
                        n_h     = shs_pkg::H_INIT;
                        n_bits  = '0;
                        n_pad   = 1'b0;
                        n_done  = 1'b0;
                        n_state = shs_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = shs_pkg::ST_IDLE;
            end
        endcase

        if (sh_en) begin
            n_blk  = blk_in;
            n_fill = r_fill + 6'd1;
            if (r_fill == shs_pkg::FILL_LAST) begin
                // block complete: load schedule window and working variables
                for (int i = 0; i < 16; i++) begin
                    n_w[i] = blk_in[511 - 32 * i -: 32];
                end
                n_v     = r_h;
                n_round = '0;
                n_state = shs_pkg::ST_COMP;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_word   = r_oword;
    assign o_index  = r_oidx;
    assign o_last   = (r_oidx == shs_pkg::WORD_LAST);

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: input queue front end plus core.
// Depends on shs_pkg, shs_front and shs_core.
//
// Use: the message goes in on the slave stream one byte per transaction.
// tuser set means tdata carries a byte; tlast marks the end of the message,
// with or without a byte (tlast with tuser clear ends the message there, so
// an empty message is a single such transaction). Transactions with neither
// flag are taken and ignored.
// After the end the master stream gives eight 32-bit digest words, word 0
// first, index on tuser, tlast on word 7; the next message then starts from
// the initial hash.
// Timing: the core takes one plain byte per cycle when idle. Every 64th byte
// (message or pad) starts the compression: 64 rounds at one round a cycle,
// then the hash update, during which the core takes no command. The pad
// goes in at one pad byte per cycle; when it spills into a second block,
// a second compression comes before word 0 goes out.
// A four-deep command queue lets the input side take up to four transactions
// while the core compresses or waits on the receiver.
// Reset (synchronous, active low) empties the queue, drops any partial
// message and restores the initial hash. A stalled receiver holds the
// current word; the core waits with the next one, and the queue fills.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic        i_s_axis_tuser,  // [0] has_byte
    input  logic        i_s_axis_tlast,  // end_of_message
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,  // [2:0] word_index
    output logic        o_m_axis_tlast   // last_word
);

    shs_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    shs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_has       (i_s_axis_tuser),
        .i_fin       (i_s_axis_tlast),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    shs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_word      (o_m_axis_tdata),
        .o_index     (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// ===== rtl/shs_checker.sv =====
// Port-level checks of the SHA-256 stream hasher digest output.
// Bound to sha256_stream_hasher; depends on nothing else.
module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("digest valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled digest word changed");

    // words of one digest follow back to back, in order
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && (o_m_axis_tuser == $past(o_m_axis_tuser) + 3'd1))
        else $error("digest word missing or out of order");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == 3'd7)))
        else $error("tlast not on word 7");

    // a new digest needs at least one compression first
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=> !o_m_axis_tvalid)
        else $error("digest words directly after a finished digest");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
